[hdl/bfsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_pkg
// shared types and codes for the best-fit segment allocator
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int FIELD_ADDR_BITS = 24;
  localparam int CFG_DATA_BITS   = 25;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int RANK_BITS       = 16;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SPLIT   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_BADARG   = 2'd3;

  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_HEAP_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SPLIT_THR  = 2'd2;

  localparam logic [23:0] SPLIT_THR_RESET = 24'd512;

  typedef struct packed {
    logic [1:0]  operation;
    logic [23:0] request_length;
    logic [23:0] segment_address;
    logic [23:0] cut_address;
  } in_item_t;

  typedef struct packed {
    logic [23:0] granted_address;
    logic [1:0]  status;
  } out_item_t;

endpackage
`default_nettype wire

[hdl/best_fit_segment_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// segment table with best-fit allocate, coalescing release and split
// ----------------------------------------------------------------------------
// sequence: allocate, split and bad operations scan the table once between
//   acceptance and result valid, and may write a second descriptor;
//   release scans the table twice and writes a second descriptor on a merge
// flow: one transaction at a time, set by the single table read port walked
//   one entry per cycle; a result held by out_stall holds it
// reset: after rst, the descriptor table is cleared one entry per
//   cycle; no transaction is accepted until that pass ends
module best_fit_segment_allocator import bfsa_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_item_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_data,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AB = FIELD_ADDR_BITS;
  localparam int EB = AB + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  typedef struct packed {
    logic          valid;
    logic          free;
    logic [AB-1:0] start;
    logic [EB-1:0] stop;
    logic [RANK_BITS-1:0] rank;
  } ent_t;

  ent_t mem [ENTRIES];
  ent_t rd;

  logic [2:0]  state;
  logic [IB:0] cnt;
  in_item_t    req;
  out_item_t   res;
  out_item_t   pend;
  out_item_t   pend_next;
  logic        res_valid;

  logic [EB-1:0] heap_limit;
  logic [AB-1:0] split_threshold;
  logic [EB-1:0] bump_pointer;
  logic [RANK_BITS-1:0] rank_counter;

  logic          rd_ok;
  logic [IB-1:0] rd_idx;
  logic          best_ok, empty_ok, pick_ok;
  logic [IB-1:0] best_idx, empty_idx, pick_idx, busy_idx;
  logic          busy_ok;
  logic [EB-1:0] best_len;
  logic [RANK_BITS-1:0] best_rank, pick_rank;
  ent_t          best_e, pick_e, busy_e;

  logic          we;
  logic [IB-1:0] wa;
  ent_t          wd;
  logic          we2;
  logic [IB-1:0] wa2;
  ent_t          wd2;
  logic          we2_next;
  logic [IB-1:0] wa2_next;
  ent_t          wd2_next;
  logic          bump_take;
  logic          rank_take;
  logic          wphase;
  logic          wb_first;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[rd_idx];
  end

  assign rd_idx = cnt[IB-1:0];
  assign in_stall = (state != S_IDLE);
  assign out_valid = res_valid;
  assign out_data = res;

  logic [EB-1:0] rlen, req_len_e, limit_cap, bump_end;
  logic [EB:0]   len_thr;
  always_comb begin
    req_len_e = {1'b0, req.request_length};
    rlen = rd.stop - {1'b0, rd.start};
    len_thr = {1'b0, req_len_e} + {2'b0, split_threshold};
    limit_cap = heap_limit[EB-1] ? {1'b1, {AB{1'b0}}} : heap_limit;
    bump_end = bump_pointer + req_len_e;
  end

  // outcome of the scan
  always_comb begin
    pend_next = '0;
    pend_next.status = ST_OK;
    we2_next = 1'b0;
    wa2_next = '0;
    wd2_next = '0;
    bump_take = 1'b0;
    rank_take = 1'b0;
    case (req.operation)
      OP_ALLOC: begin
        if (req.request_length == '0) begin
          pend_next.status = ST_BADARG;
        end else if (best_ok) begin
          pend_next.granted_address = best_e.start;
          if ({1'b0, best_len} > len_thr && empty_ok) begin
            we2_next = 1'b1;
            wa2_next = best_idx;
            wd2_next = best_e;
            wd2_next.start = best_e.start + req.request_length;
          end
        end else if ({1'b0, bump_end} > {1'b0, limit_cap} || !empty_ok) begin
          pend_next.status = ST_NOSPACE;
        end else begin
          pend_next.granted_address = bump_pointer[AB-1:0];
          bump_take = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!busy_ok) begin
          pend_next.status = ST_NOTFOUND;
        end else if (!pick_ok) begin
          rank_take = 1'b1;
        end else begin
          we2_next = 1'b1;
          wa2_next = pick_idx;
          wd2_next = pick_e;
          if (pick_e.stop == {1'b0, busy_e.start}) begin
            wd2_next.stop = busy_e.stop;
          end else begin
            wd2_next.start = busy_e.start;
          end
        end
      end
      OP_SPLIT: begin
        if (req.cut_address <= req.segment_address) begin
          pend_next.status = ST_BADARG;
        end else if (!busy_ok) begin
          pend_next.status = ST_NOTFOUND;
        end else if ({1'b0, req.cut_address} > busy_e.stop) begin
          pend_next.status = ST_BADARG;
        end else if ({1'b0, req.cut_address} == busy_e.stop) begin
          pend_next.status = ST_OK;
        end else if (!empty_ok) begin
          pend_next.status = ST_NOSPACE;
        end else begin
          we2_next = 1'b1;
          wa2_next = empty_idx;
          wd2_next = '{valid: 1'b1, free: 1'b0, start: req.cut_address,
                       stop: busy_e.stop, rank: '0};
        end
      end
      default: pend_next.status = ST_BADARG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      res_valid <= 1'b0;
      heap_limit <= {1'b1, {AB{1'b0}}};
      split_threshold <= SPLIT_THR_RESET;
      bump_pointer <= '0;
      rank_counter <= '0;
      rd_ok <= 1'b0;
      we2 <= 1'b0;
      wphase <= 1'b0;
    end else begin
      if (state == S_OUT && (!res_valid || !out_stall)) begin
        res_valid <= 1'b1;
        res <= pend;
      end else if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_HEAP_LIMIT: heap_limit <= cfg_data;
          CFG_SPLIT_THR: split_threshold <= cfg_data[AB-1:0];
          default: ;
        endcase
      end
      if (cfg_write && cfg_index == CFG_HEAP_BASE) begin
        bump_pointer <= {1'b0, cfg_data[AB-1:0]};
      end else if (state == S_DEC && bump_take) begin
        bump_pointer <= bump_end;
      end
      if (state == S_DEC && rank_take) begin
        rank_counter <= rank_counter + 1'b1;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (IB+1)'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            cnt <= '0;
            rd_ok <= 1'b0;
            best_ok <= 1'b0;
            empty_ok <= 1'b0;
            pick_ok <= 1'b0;
            busy_ok <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_ok && cnt == (IB+1)'(ENTRIES)) begin
            rd_ok <= 1'b0;
            if (req.operation == OP_RELEASE && !wphase) begin
              wphase <= 1'b1;
              cnt <= '0;
            end else begin
              state <= S_DEC;
            end
          end else begin
            rd_ok <= (cnt < (IB+1)'(ENTRIES));
            if (cnt < (IB+1)'(ENTRIES)) begin
              cnt <= cnt + 1'b1;
            end
          end
          if (rd_ok) begin
            if (!rd.valid) begin
              if (!empty_ok) begin
                empty_ok <= 1'b1;
                empty_idx <= rd_idx - 1'b1;
              end
            end else if (rd.free) begin
              if (rlen >= req_len_e &&
                  (!best_ok || rlen < best_len ||
                   (rlen == best_len && rd.rank < best_rank))) begin
                best_ok <= 1'b1;
                best_idx <= rd_idx - 1'b1;
                best_len <= rlen;
                best_rank <= rd.rank;
                best_e <= rd;
              end
            end else if (!busy_ok && rd.start == req.segment_address) begin
              busy_ok <= 1'b1;
              busy_idx <= rd_idx - 1'b1;
              busy_e <= rd;
            end
          end
          if (wphase && rd_ok && rd.valid && rd.free &&
              (rd.stop == {1'b0, busy_e.start} || {1'b0, rd.start} == busy_e.stop) &&
              (!pick_ok || rd.rank < pick_rank)) begin
            pick_ok <= 1'b1;
            pick_idx <= rd_idx - 1'b1;
            pick_rank <= rd.rank;
            pick_e <= rd;
          end
        end
        S_DEC: begin
          state <= S_WB;
          pend <= pend_next;
          we2 <= we2_next;
          wa2 <= wa2_next;
          wd2 <= wd2_next;
        end
        S_WB: begin
          if (!(wb_first && we2)) begin
            state <= S_OUT;
            we2 <= 1'b0;
          end
        end
        S_OUT: begin
          if (!res_valid || !out_stall) begin
            state <= S_IDLE;
            wphase <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // primary write in S_WB, secondary (we2) in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_first <= 1'b0;
    end else begin
      wb_first <= (state == S_DEC);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = cnt[IB-1:0];
    end else if (state == S_WB && wb_first) begin
      case (req.operation)
        OP_ALLOC: begin
          if (pend.status == ST_OK) begin
            if (best_ok && we2) begin
              we = 1'b1;
              wa = empty_idx;
              wd = '{valid: 1'b1, free: 1'b0, start: best_e.start,
                     stop: {1'b0, best_e.start} + req_len_e, rank: '0};
            end else if (best_ok) begin
              we = 1'b1;
              wa = best_idx;
              wd = best_e;
              wd.free = 1'b0;
            end else begin
              we = 1'b1;
              wa = empty_idx;
              wd = '{valid: 1'b1, free: 1'b0, start: pend.granted_address,
                     stop: bump_pointer, rank: '0};
            end
          end
        end
        OP_RELEASE: begin
          if (pend.status == ST_OK) begin
            we = 1'b1;
            wa = busy_idx;
            if (we2) begin
              wd = '0;
            end else begin
              wd = busy_e;
              wd.free = 1'b1;
              wd.rank = rank_counter - 1'b1;
            end
          end
        end
        OP_SPLIT: begin
          if (pend.status == ST_OK && we2) begin
            we = 1'b1;
            wa = busy_idx;
            wd = busy_e;
            wd.stop = {1'b0, req.cut_address};
          end
        end
        default: ;
      endcase
    end else if (state == S_WB && we2) begin
      we = 1'b1;
      wa = wa2;
      wd = wd2;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");
  a_clear_first: assert property (@(posedge clk)
    $past(rst) |-> (state == S_CLEAR || rst))
    else $error("clear pass skipped");

endmodule
`default_nettype wire

[tb/best_fit_segment_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_tb
// drives allocate, release, split and unknown-operation transactions through the segment
// allocator under random idle and stall, predicts every result with its own
// copy of the descriptor table and compares results in order
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_tb;
  import bfsa_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [24:0] SPAN = 25'h1000000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  best_fit_segment_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted descriptor table
  logic        seg_valid [SLOTS];
  logic        seg_free [SLOTS];
  logic [23:0] seg_lo [SLOTS];
  logic [24:0] seg_hi [SLOTS];
  logic [15:0] seg_age [SLOTS];
  logic [15:0] age_next;
  logic [24:0] bump_ptr;
  logic [24:0] cfg_limit;
  logic [23:0] cfg_thresh;

  out_item_t pending_results[$];
  bit failed;
  bit quiet;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int empty_entry();
    for (int i = 0; i < SLOTS; i++)
      if (!seg_valid[i]) return i;
    return -1;
  endfunction

  function automatic int busy_entry(logic [23:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (seg_valid[i] && !seg_free[i] && seg_lo[i] == a) return i;
    return -1;
  endfunction

  function automatic out_item_t alloc_segment(logic [23:0] len);
    out_item_t r;
    int best;
    int slot;
    logic [24:0] best_len;
    logic [24:0] l;
    logic [25:0] lim;
    r = '0;
    best = -1;
    best_len = '0;
    if (len == 0) begin
      r.status = ST_BADARG;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!seg_valid[i] || !seg_free[i]) continue;
      l = seg_hi[i] - {1'b0, seg_lo[i]};
      if (l < {1'b0, len}) continue;
      if (best < 0 || l < best_len || (l == best_len && seg_age[i] < seg_age[best])) begin
        best = i;
        best_len = l;
      end
    end
    if (best >= 0) begin
      slot = -1;
      if ({1'b0, best_len} > {2'b0, len} + {2'b0, cfg_thresh}) slot = empty_entry();
      if (slot >= 0) begin
        seg_valid[slot] = 1'b1;
        seg_free[slot] = 1'b0;
        seg_lo[slot] = seg_lo[best];
        seg_hi[slot] = {1'b0, seg_lo[best]} + {1'b0, len};
        seg_age[slot] = '0;
        seg_lo[best] = seg_lo[best] + len;
        r.granted_address = seg_lo[slot];
      end else begin
        seg_free[best] = 1'b0;
        r.granted_address = seg_lo[best];
      end
      r.status = ST_OK;
      return r;
    end
    lim = (cfg_limit > SPAN) ? {1'b0, SPAN} : {1'b0, cfg_limit};
    if ({1'b0, bump_ptr} + {2'b0, len} > lim) begin
      r.status = ST_NOSPACE;
      return r;
    end
    slot = empty_entry();
    if (slot < 0) begin
      r.status = ST_NOSPACE;
      return r;
    end
    seg_valid[slot] = 1'b1;
    seg_free[slot] = 1'b0;
    seg_lo[slot] = bump_ptr[23:0];
    seg_hi[slot] = bump_ptr + {1'b0, len};
    seg_age[slot] = '0;
    bump_ptr = bump_ptr + {1'b0, len};
    r.granted_address = seg_lo[slot];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic [1:0] release_segment(logic [23:0] a);
    int p;
    int pick;
    p = busy_entry(a);
    pick = -1;
    if (p < 0) return ST_NOTFOUND;
    for (int i = 0; i < SLOTS; i++) begin
      if (!seg_valid[i] || !seg_free[i]) continue;
      if (seg_hi[i] != {1'b0, seg_lo[p]} && {1'b0, seg_lo[i]} != seg_hi[p]) continue;
      if (pick < 0 || seg_age[i] < seg_age[pick]) pick = i;
    end
    if (pick >= 0) begin
      if (seg_hi[pick] == {1'b0, seg_lo[p]}) seg_hi[pick] = seg_hi[p];
      else seg_lo[pick] = seg_lo[p];
      seg_valid[p] = 1'b0;
      seg_free[p] = 1'b0;
      seg_lo[p] = '0;
      seg_hi[p] = '0;
      seg_age[p] = '0;
      return ST_OK;
    end
    seg_free[p] = 1'b1;
    seg_age[p] = age_next;
    age_next = age_next + 16'd1;
    return ST_OK;
  endfunction

  function automatic logic [1:0] split_segment(logic [23:0] a, logic [23:0] cut);
    int m;
    int slot;
    if (cut <= a) return ST_BADARG;
    m = busy_entry(a);
    if (m < 0) return ST_NOTFOUND;
    if ({1'b0, cut} > seg_hi[m]) return ST_BADARG;
    if ({1'b0, cut} == seg_hi[m]) return ST_OK;
    slot = empty_entry();
    if (slot < 0) return ST_NOSPACE;
    seg_valid[slot] = 1'b1;
    seg_free[slot] = 1'b0;
    seg_lo[slot] = cut;
    seg_hi[slot] = seg_hi[m];
    seg_age[slot] = '0;
    seg_hi[m] = {1'b0, cut};
    return ST_OK;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.operation)
      OP_ALLOC: r = alloc_segment(it.request_length);
      OP_RELEASE: r.status = release_segment(it.segment_address);
      OP_SPLIT: r.status = split_segment(it.segment_address, it.cut_address);
      default: r.status = ST_BADARG;
    endcase
    return r;
  endfunction

  // random busy entry index, -1 when none
  function automatic int any_busy();
    int list[$];
    for (int i = 0; i < SLOTS; i++)
      if (seg_valid[i] && !seg_free[i]) list.push_back(i);
    if (list.size() == 0) return -1;
    return list[$urandom_range(0, list.size() - 1)];
  endfunction

  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(it));
  endtask

  task automatic send_op(logic [1:0] op, logic [23:0] len, logic [23:0] a, logic [23:0] cut);
    in_item_t it;
    it.operation = op;
    it.request_length = len;
    it.segment_address = a;
    it.cut_address = cut;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_HEAP_BASE: bump_ptr = {1'b0, val[23:0]};
      CFG_HEAP_LIMIT: cfg_limit = val;
      CFG_SPLIT_THR: cfg_thresh = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(OP_ALLOC, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_op(OP_UNKNOWN, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_op(OP_ALLOC, 24'hFFFFFF, 24'd0, 24'd0);
    send_op(OP_ALLOC, 24'd1, 24'd0, 24'd0);
    send_op(OP_SPLIT, 24'd0, 24'd0, 24'd0);
    send_op(OP_SPLIT, 24'd0, 24'd0, 24'hFFFFFF);
    send_op(OP_SPLIT, 24'd0, 24'd0, 24'h800000);
    send_op(OP_SPLIT, 24'd0, 24'd0, 24'h800000);
    send_op(OP_SPLIT, 24'd0, 24'h800000, 24'hFFFFFF);
    send_op(OP_SPLIT, 24'd0, 24'h123456, 24'h200000);
    send_op(OP_RELEASE, 24'd0, 24'h123456, 24'd0);
    send_op(OP_RELEASE, 24'd0, 24'h800000, 24'd0);
    send_op(OP_RELEASE, 24'd0, 24'd0, 24'd0);
    send_op(OP_ALLOC, 24'd100, 24'd0, 24'd0);
    send_op(OP_ALLOC, 24'd700, 24'd0, 24'd0);
    send_op(OP_ALLOC, 24'h7FFFFF, 24'd0, 24'd0);
    send_op(OP_RELEASE, 24'd0, 24'd0, 24'd0);
    send_op(OP_ALLOC, 24'h7FFF9C, 24'd0, 24'd0);
    send_op(OP_RELEASE, 24'd0, 24'd0, 24'd0);
    send_op(OP_RELEASE, 24'd0, 24'd100, 24'd0);
    send_op(OP_ALLOC, 24'd2, 24'd0, 24'd0);
    drain();
  endtask

  task automatic random_item();
    int pick;
    int sel;
    logic [23:0] len;
    logic [23:0] a;
    logic [23:0] cut;
    sel = $urandom_range(0, 99);
    len = 24'($urandom_range(1, 2048));
    a = 24'($urandom);
    cut = 24'($urandom);
    pick = any_busy();
    if (sel < 45) begin
      case ($urandom_range(0, 19))
        0: len = 24'd0;
        1: len = 24'($urandom);
        2: len = 24'($urandom_range(1, 16));
        default: ;
      endcase
      send_op(OP_ALLOC, len, a, cut);
    end else if (sel < 80) begin
      if (pick >= 0 && $urandom_range(0, 99) < 85) a = seg_lo[pick];
      send_op(OP_RELEASE, len, a, cut);
    end else if (sel < 96) begin
      if (pick >= 0 && $urandom_range(0, 99) < 85) begin
        a = seg_lo[pick];
        case ($urandom_range(0, 9))
          0: cut = seg_hi[pick][23:0];
          1: cut = a;
          2: cut = seg_hi[pick][23:0] + 24'd1;
          default: if (seg_hi[pick] > {1'b0, a} + 25'd1)
            cut = a + 24'd1 + 24'($urandom_range(0, int'(seg_hi[pick] - a - 25'd2)));
        endcase
      end
      send_op(OP_SPLIT, len, a, cut);
    end else begin
      send_op(OP_UNKNOWN, len, a, cut);
    end
  endtask

  task automatic test_random(int count, logic [23:0] base, logic [24:0] lim, logic [23:0] thr);
    write_reg(CFG_HEAP_BASE, {1'b0, base});
    write_reg(CFG_HEAP_LIMIT, lim);
    write_reg(CFG_SPLIT_THR, {1'b0, thr});
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 2);
      random_item();
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_table_full();
    int pick;
    write_reg(CFG_HEAP_BASE, 25'h400000);
    write_reg(CFG_HEAP_LIMIT, SPAN);
    write_reg(CFG_SPLIT_THR, 25'd0);
    for (int n = 0; n < 72; n++) send_op(OP_ALLOC, 24'd64, 24'd0, 24'd0);
    pick = any_busy();
    if (pick >= 0) send_op(OP_SPLIT, 24'd0, seg_lo[pick], seg_lo[pick] + 24'd8);
    send_op(OP_ALLOC, 24'd5000, 24'd0, 24'd0);
    for (int n = 0; n < 6; n++) begin
      pick = any_busy();
      if (pick >= 0) send_op(OP_RELEASE, 24'd0, seg_lo[pick], 24'd0);
    end
    for (int n = 0; n < 6; n++) send_op(OP_ALLOC, 24'd3, 24'd0, 24'd0);
    for (int n = 0; n < 40; n++) random_item();
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !quiet && ($urandom_range(0, 99) < 6);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted_address !== want.granted_address) begin
          $error("granted_address expected %h actual %h", want.granted_address,
                 out_data.granted_address);
          failed = 1'b1;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      seg_valid[i] = 1'b0;
      seg_free[i] = 1'b0;
      seg_lo[i] = '0;
      seg_hi[i] = '0;
      seg_age[i] = '0;
    end
    age_next = '0;
    cfg_limit = SPAN;
    cfg_thresh = SPLIT_THR_RESET;
    bump_ptr = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(450, 24'h000000, SPAN, 24'd512);
    test_random(450, 24'h001000, 25'h040000, 24'd0);
    test_random(300, 24'hFFFF00, SPAN, 24'hFFFFFF);
    test_random(150, 24'h0ABCDE, 25'd0, 24'd16);
    test_random(350, 24'h100000, 25'h1FFFFFF, 24'd64);
    test_table_full();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
